// ===== rtl/core/dbs_pkg.sv =====
// Shared types, constants and lookup function of the depth background subtractor.
package dbs_pkg;

    localparam int FRAME_PIXELS = 76800;
    localparam int IDX_W        = 17;
    localparam int PIX_W        = 8;
    localparam int OP_W         = 2;
    localparam int DIV_W        = 4;
    localparam int ADDR_W       = $clog2(FRAME_PIXELS);

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    // Blend: floor(sum / 5) as (sum * 13108) >> 16, exact for sum up to 1275
    localparam int SUM_W       = PIX_W + 3;
    localparam int BLEND_MUL   = 13108;
    localparam int BLEND_MUL_W = 14;
    localparam int BLEND_SHIFT = 16;
    localparam int BLEND_PROD_W = SUM_W + BLEND_MUL_W;

    // Divisor: floor(diff / d) as (diff * ceil(4096 / d)) >> 12, exact for 8-bit diff
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 12;
    localparam int DIV_PROD_W  = PIX_W + RECIP_W;

    localparam logic [PIX_W-1:0] NOISE_FLOOR = PIX_W'(3);

    localparam logic CFG_AUTO_BASELINE   = 1'b0;
    localparam logic CFG_DENSITY_DIVISOR = 1'b1;

    localparam logic [DIV_W-1:0]   DIVISOR_RESET = DIV_W'(1);
    localparam logic [RECIP_W-1:0] RECIP_RESET   = RECIP_W'(4096);

    typedef enum logic [OP_W-1:0] {
        OP_PROCESS = 2'd0,
        OP_CAPTURE = 2'd1,
        OP_CLEAR   = 2'd2
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] idx;
        logic [PIX_W-1:0] depth;
    } cmd_t;

    typedef struct packed {
        logic [PIX_W-1:0] fg;
        logic [IDX_W-1:0] idx;
    } res_t;

    // Reciprocal of the density divisor; zero divides as one
    function automatic logic [RECIP_W-1:0] recip_of(input logic [DIV_W-1:0] d);
        logic [RECIP_W-1:0] r;
        case (d)
            4'd0:    r = 13'd4096;
            4'd1:    r = 13'd4096;
            4'd2:    r = 13'd2048;
            4'd3:    r = 13'd1366;
            4'd4:    r = 13'd1024;
            4'd5:    r = 13'd820;
            4'd6:    r = 13'd683;
            4'd7:    r = 13'd586;
            4'd8:    r = 13'd512;
            4'd9:    r = 13'd456;
            4'd10:   r = 13'd410;
            4'd11:   r = 13'd373;
            4'd12:   r = 13'd342;
            4'd13:   r = 13'd316;
            4'd14:   r = 13'd293;
            default: r = 13'd274;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/dbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/dbs_front.sv =====
// Front end: accepts pixel beats, drops unused opcodes and off-frame indexes, queues commands.
module dbs_front
    import dbs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pix_valid,
    output logic             pix_stall,
    input  logic [OP_W-1:0]  opcode,
    input  logic [IDX_W-1:0] pixel_index,
    input  logic [PIX_W-1:0] depth,
    input  logic             busy,
    input  logic             cmd_pop,
    output logic             cmd_valid,
    output cmd_t             cmd
);

    cmd_t                  q_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  accept;
    logic                  keep;
    logic                  push;
    logic                  pop;

    assign pix_stall = busy || (cnt_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign accept    = pix_valid && !pix_stall;

    always_comb
    begin
        keep = 1'b0;
        if (pixel_index < IDX_W'(FRAME_PIXELS))
        begin
            unique case (opcode)
                OP_PROCESS, OP_CAPTURE, OP_CLEAR: keep = 1'b1;
                default:                          keep = 1'b0;
            endcase
        end
    end

    assign push      = accept && keep;
    assign cmd_valid = (cnt_reg != '0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + CMDQ_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + CMDQ_PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + CMDQ_CNT_W'(push) - CMDQ_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{op: op_t'(opcode), idx: pixel_index, depth: depth};
        end
    end

endmodule

// ===== rtl/core/dbs_back.sv =====
// Back end: baseline store, read-modify-write pipeline, divider stage and result queue.
module dbs_back
    import dbs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  cmd_t               cmd,
    output logic               cmd_pop,
    output logic               busy,
    input  logic               auto_baseline,
    input  logic [RECIP_W-1:0] recip,
    output logic               res_valid,
    input  logic               res_stall,
    output logic [PIX_W-1:0]   foreground,
    output logic [IDX_W-1:0]   out_index
);

    // clearing pass
    logic              clr_active_reg, clr_active_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;

    // pipeline stages
    logic                    s2_valid_reg, s2_valid_next;
    cmd_t                    s2_cmd_reg;
    logic                    s3_valid_reg, s3_valid_next;
    cmd_t                    s3_cmd_reg;
    logic [PIX_W-1:0]        s3_base_reg;
    logic [BLEND_PROD_W-1:0] s3_prod_reg;
    logic                    s4_valid_reg, s4_valid_next;
    logic [IDX_W-1:0]        s4_idx_reg;
    logic [DIV_PROD_W-1:0]   s4_prod_reg;

    // last write to the store, for forwarding
    logic              pw_valid_reg, pw_valid_next;
    logic [ADDR_W-1:0] pw_addr_reg;
    logic [PIX_W-1:0]  pw_data_reg;

    // result queue
    res_t                  oq_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] oq_wr_reg, oq_wr_next;
    logic [OUTQ_PTR_W-1:0] oq_rd_reg, oq_rd_next;
    logic [OUTQ_CNT_W-1:0] oq_cnt_reg, oq_cnt_next;

    logic [OUTQ_CNT_W:0]     occupancy;
    logic                    issue;
    logic                    s2_proc;
    logic                    s3_proc;
    logic [PIX_W-1:0]        ram_rdata;
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [PIX_W-1:0]        ram_wdata;
    logic                    s3_we;
    logic [PIX_W-1:0]        s3_blend;
    logic [PIX_W-1:0]        s3_wdata;
    logic [PIX_W-1:0]        s3_cur;
    logic [PIX_W-1:0]        s3_diff;
    logic [PIX_W-1:0]        s2_base;
    logic [SUM_W-1:0]        s2_sum;
    logic [BLEND_PROD_W-1:0] s2_prod;
    logic [DIV_PROD_W-1:0]   s3_dprod;
    logic [PIX_W-1:0]        s4_quot;
    logic [PIX_W-1:0]        s4_fg;
    logic                    oq_push;
    logic                    oq_pop;

    assign busy = clr_active_reg;

    // Reserve a queue slot for every result still in flight before issuing
    assign s2_proc   = s2_valid_reg && (s2_cmd_reg.op == OP_PROCESS);
    assign s3_proc   = s3_valid_reg && (s3_cmd_reg.op == OP_PROCESS);
    assign occupancy = (OUTQ_CNT_W + 1)'(oq_cnt_reg) + (OUTQ_CNT_W + 1)'(s2_proc)
                     + (OUTQ_CNT_W + 1)'(s3_proc) + (OUTQ_CNT_W + 1)'(s4_valid_reg);
    assign issue     = cmd_valid && !clr_active_reg
                     && (occupancy < (OUTQ_CNT_W + 1)'(OUTQ_DEPTH));
    assign cmd_pop   = issue;

    dbs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (FRAME_PIXELS)
    ) u_baseline (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (cmd.idx[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // Stage 3 write-back value
    always_comb
    begin
        s3_blend = s3_prod_reg[BLEND_SHIFT +: PIX_W];
        case (s3_cmd_reg.op)
            OP_PROCESS: s3_wdata = s3_blend;
            OP_CAPTURE: s3_wdata = s3_cmd_reg.depth;
            default:    s3_wdata = '0;
        endcase
        s3_we = s3_valid_reg && ((s3_cmd_reg.op != OP_PROCESS) || auto_baseline);
    end

    always_comb
    begin
        if (clr_active_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = s3_we;
            ram_waddr = s3_cmd_reg.idx[ADDR_W-1:0];
            ram_wdata = s3_wdata;
        end
    end

    // Stage 2: forward the write in flight and the one issued with this read
    always_comb
    begin
        if (s3_we && (s3_cmd_reg.idx == s2_cmd_reg.idx))
        begin
            s2_base = s3_wdata;
        end
        else if (pw_valid_reg && (pw_addr_reg == s2_cmd_reg.idx[ADDR_W-1:0]))
        begin
            s2_base = pw_data_reg;
        end
        else
        begin
            s2_base = ram_rdata;
        end
        s2_sum  = SUM_W'(s2_cmd_reg.depth) + {1'b0, s2_base, 2'b00};
        s2_prod = BLEND_PROD_W'(s2_sum) * BLEND_PROD_W'(BLEND_MUL);
    end

    // Stage 3: absolute difference and scaling by the divisor reciprocal
    always_comb
    begin
        s3_cur   = auto_baseline ? s3_blend : s3_base_reg;
        s3_diff  = (s3_cmd_reg.depth >= s3_cur) ? s3_cmd_reg.depth - s3_cur
                                                : s3_cur - s3_cmd_reg.depth;
        s3_dprod = DIV_PROD_W'(s3_diff) * DIV_PROD_W'(recip);
    end

    // Stage 4: truncate and suppress noise
    always_comb
    begin
        s4_quot = s4_prod_reg[RECIP_SHIFT +: PIX_W];
        s4_fg   = (s4_quot < NOISE_FLOOR) ? '0 : s4_quot;
    end

    assign oq_push    = s4_valid_reg;
    assign res_valid  = (oq_cnt_reg != '0);
    assign oq_pop     = res_valid && !res_stall;
    assign foreground = oq_reg[oq_rd_reg].fg;
    assign out_index  = oq_reg[oq_rd_reg].idx;

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(FRAME_PIXELS - 1))
            begin
                clr_active_next = 1'b0;
            end
        end
        s2_valid_next = issue;
        s3_valid_next = s2_valid_reg;
        s4_valid_next = s3_proc;
        pw_valid_next = s3_we;
        oq_wr_next    = oq_push ? oq_wr_reg + OUTQ_PTR_W'(1) : oq_wr_reg;
        oq_rd_next    = oq_pop ? oq_rd_reg + OUTQ_PTR_W'(1) : oq_rd_reg;
        oq_cnt_next   = oq_cnt_reg + OUTQ_CNT_W'(oq_push) - OUTQ_CNT_W'(oq_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            pw_valid_reg   <= 1'b0;
            oq_wr_reg      <= '0;
            oq_rd_reg      <= '0;
            oq_cnt_reg     <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            s2_valid_reg   <= s2_valid_next;
            s3_valid_reg   <= s3_valid_next;
            s4_valid_reg   <= s4_valid_next;
            pw_valid_reg   <= pw_valid_next;
            oq_wr_reg      <= oq_wr_next;
            oq_rd_reg      <= oq_rd_next;
            oq_cnt_reg     <= oq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_cmd_reg  <= cmd;
        s3_cmd_reg  <= s2_cmd_reg;
        s3_base_reg <= s2_base;
        s3_prod_reg <= s2_prod;
        s4_idx_reg  <= s3_cmd_reg.idx;
        s4_prod_reg <= s3_dprod;
        pw_addr_reg <= s3_cmd_reg.idx[ADDR_W-1:0];
        pw_data_reg <= s3_wdata;
        if (oq_push)
        begin
            oq_reg[oq_wr_reg] <= '{fg: s4_fg, idx: s4_idx_reg};
        end
    end

    a_oq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg |-> (oq_cnt_reg != OUTQ_CNT_W'(OUTQ_DEPTH)))
        else $error("result queue overflow");

    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        !clr_active_reg |=> !clr_active_reg)
        else $error("clearing pass restarted");

    a_no_work_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> (!s2_valid_reg && !s3_valid_reg && !s4_valid_reg))
        else $error("pipeline busy during clearing pass");

    a_result_from_process: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg |-> $past(s3_valid_reg && (s3_cmd_reg.op == OP_PROCESS)))
        else $error("result without a process command");

endmodule

// ===== rtl/core/depth_background_subtract.sv =====
// Top level of the depth background subtractor: configuration registers and front/back wiring.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------
//   pixel   | in        | pix_valid / pix_stall | opcode, pixel_index, depth
//   result  | out       | res_valid / res_stall | foreground, out_index
//   config  | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One pixel beat per cycle is accepted while pix_stall is low.
// The rate is set by the baseline RAM's one read port and one write port, one access each a cycle.
// After reset a clearing pass zeroes all FRAME_PIXELS (76800) entries of the baseline RAM;
// pix_stall stays high during it, configuration writes are taken as usual.
// res_stall fills an eight-entry result queue, then the four-entry command queue, then
// raises pix_stall. Capture, clear, opcode 3 and off-frame beats give no result.
module depth_background_subtract
    import dbs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pix_valid,
    output logic             pix_stall,
    input  logic [OP_W-1:0]  opcode,
    input  logic [IDX_W-1:0] pixel_index,
    input  logic [PIX_W-1:0] depth,
    output logic             res_valid,
    input  logic             res_stall,
    output logic [PIX_W-1:0] foreground,
    output logic [IDX_W-1:0] out_index,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [DIV_W-1:0] cfg_data
);

    logic               auto_reg, auto_next;
    logic [DIV_W-1:0]   divisor_reg, divisor_next;
    logic [RECIP_W-1:0] recip_reg, recip_next;
    logic               cfg_write;
    logic               busy;
    logic               cmd_valid;
    logic               cmd_pop;
    cmd_t               cmd;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        auto_next    = auto_reg;
        divisor_next = divisor_reg;
        recip_next   = recip_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_AUTO_BASELINE:
                begin
                    auto_next = cfg_data[0];
                end
                CFG_DENSITY_DIVISOR:
                begin
                    divisor_next = cfg_data;
                    recip_next   = recip_of(cfg_data);
                end
                default:
                begin
                    auto_next = auto_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_reg    <= 1'b0;
            divisor_reg <= DIVISOR_RESET;
            recip_reg   <= RECIP_RESET;
        end
        else
        begin
            auto_reg    <= auto_next;
            divisor_reg <= divisor_next;
            recip_reg   <= recip_next;
        end
    end

    dbs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pix_valid   (pix_valid),
        .pix_stall   (pix_stall),
        .opcode      (opcode),
        .pixel_index (pixel_index),
        .depth       (depth),
        .busy        (busy),
        .cmd_pop     (cmd_pop),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd)
    );

    dbs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .busy          (busy),
        .auto_baseline (auto_reg),
        .recip         (recip_reg),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .foreground    (foreground),
        .out_index     (out_index)
    );

    a_recip_matches: assert property (@(posedge clk) disable iff (!rst_n)
        recip_reg == recip_of(divisor_reg))
        else $error("divisor reciprocal out of step");

    a_stall_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> pix_stall)
        else $error("pixel accepted during clearing pass");

    a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> (res_valid && $stable(out_index) && $stable(foreground)))
        else $error("stalled result changed");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for depth_background_subtract: directed ops, config sweep, backpressure.
module tb_top;
    import dbs_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_PCT       = 26;
    // idle gaps come before this share of beats
    localparam int SEND_IDLE_PCT  = 18;
    localparam int DRAIN_CYCLES   = 16;
    localparam int HOLD_CYCLES    = 120;
    localparam int WATCHDOG_LIMIT = 320000;

    logic             clk;
    logic             rst_n       = 1'b0;
    logic             pix_valid   = 1'b0;
    logic             pix_stall;
    logic [OP_W-1:0]  opcode      = OP_PROCESS;
    logic [IDX_W-1:0] pixel_index = '0;
    logic [PIX_W-1:0] depth       = '0;
    logic             res_valid;
    logic             res_stall   = 1'b0;
    logic [PIX_W-1:0] foreground;
    logic [IDX_W-1:0] out_index;
    logic             cfg_valid   = 1'b0;
    logic             cfg_ready;
    logic             cfg_index   = CFG_AUTO_BASELINE;
    logic [DIV_W-1:0] cfg_data    = '0;

    // Predictor state: baseline store and register copies
    logic [PIX_W-1:0] base_mem [FRAME_PIXELS];
    logic             auto_on     = 1'b0;
    logic [DIV_W-1:0] div_setting = DIVISOR_RESET;
    res_t             pending_fg_q [$];

    logic calm = 1'b0;
    int   hot_pool [16];
    int   beats_sent;
    int   live_items;
    int   results_seen;
    int   reg_writes;
    int   mismatches;
    int   hold_requests;
    int   holds_done;
    int   hold_left;
    int   quiet_cycles;

    depth_background_subtract u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pix_valid   (pix_valid),
        .pix_stall   (pix_stall),
        .opcode      (opcode),
        .pixel_index (pixel_index),
        .depth       (depth),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .foreground  (foreground),
        .out_index   (out_index),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < FRAME_PIXELS; i++)
            base_mem[i] = '0;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] MISMATCH %s", $time, what);
    endtask

    function automatic void predict_foreground(input logic [OP_W-1:0] op,
                                               input logic [IDX_W-1:0] idx,
                                               input logic [PIX_W-1:0] dep);
        int   base;
        int   diff;
        int   dv;
        int   fg;
        res_t r;
        if (idx >= FRAME_PIXELS || op == OP_UNUSED)
            return;
        live_items++;
        if (op == OP_CAPTURE)
        begin
            base_mem[idx] = dep;
            return;
        end
        if (op == OP_CLEAR)
        begin
            base_mem[idx] = '0;
            return;
        end
        base = int'(base_mem[idx]);
        if (auto_on)
        begin
            base = (int'(dep) + 4 * base) / 5;
            base_mem[idx] = PIX_W'(base);
        end
        diff = (int'(dep) >= base) ? int'(dep) - base : base - int'(dep);
        dv   = (div_setting == 0) ? 1 : int'(div_setting);
        fg   = diff / dv;
        if (fg < int'(NOISE_FLOOR))
            fg = 0;
        r.fg  = PIX_W'(fg);
        r.idx = idx;
        pending_fg_q.push_back(r);
    endfunction

    // Offer one beat; hold payload until it is taken, then predict
    task automatic send_pixel(input logic [OP_W-1:0] op, input int idx, input int dep);
        if (!calm && $urandom_range(0, 99) < SEND_IDLE_PCT)
        begin
            pix_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        pix_valid   <= 1'b1;
        opcode      <= op;
        pixel_index <= IDX_W'(idx);
        depth       <= PIX_W'(dep);
        do
            @(posedge clk);
        while (pix_stall !== 1'b0);
        beats_sent++;
        predict_foreground(op, IDX_W'(idx), PIX_W'(dep));
    endtask

    task automatic wait_quiet();
        pix_valid <= 1'b0;
        while (pending_fg_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [DIV_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        if (idx == CFG_AUTO_BASELINE)
            auto_on = data[0];
        else
            div_setting = data;
        reg_writes++;
    endtask

    // Only bit 0 of the auto register counts; scramble the rest
    task automatic set_config(input int auto_val, input int div_val);
        wait_quiet();
        write_reg(CFG_AUTO_BASELINE, {3'($urandom_range(0, 7)), 1'(auto_val)});
        write_reg(CFG_DENSITY_DIVISOR, DIV_W'(div_val));
        cfg_valid <= 1'b0;
    endtask

    task automatic random_burst(input int n_items);
        int start;
        int idx;
        int d;
        int reps;
        start = live_items;
        while (live_items - start < n_items)
        begin
            if ($urandom_range(0, 99) < 75)
            begin
                idx = hot_pool[$urandom_range(0, 15)];
                if ($urandom_range(0, 1) == 1)
                    send_pixel(OP_CAPTURE, idx, $urandom_range(0, 255));
                reps = $urandom_range(1, 4);
                for (int k = 0; k < reps; k++)
                begin
                    // mostly near the baseline so the noise floor gets hit
                    if ($urandom_range(0, 2) != 0)
                    begin
                        d = int'(base_mem[idx]) + int'($urandom_range(0, 16)) - 8;
                        if (d < 0)
                            d = 0;
                        if (d > 255)
                            d = 255;
                    end
                    else
                        d = $urandom_range(0, 255);
                    send_pixel(OP_PROCESS, idx, d);
                end
                if ($urandom_range(0, 9) == 0)
                    send_pixel(OP_CLEAR, idx, $urandom_range(0, 255));
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                    idx = $urandom_range(0, 2 ** IDX_W - 1);
                else
                    idx = $urandom_range(0, FRAME_PIXELS - 1);
                send_pixel(OP_W'($urandom_range(0, 3)), idx, $urandom_range(0, 255));
            end
        end
    endtask

    task automatic test_plain_ops();
        send_pixel(OP_PROCESS, 0, 0);
        send_pixel(OP_PROCESS, FRAME_PIXELS - 1, 255);
        send_pixel(OP_PROCESS, 1, 2);
        send_pixel(OP_PROCESS, 1, 3);
        send_pixel(OP_CAPTURE, 5, 200);
        send_pixel(OP_PROCESS, 5, 255);
        send_pixel(OP_PROCESS, 5, 100);
        send_pixel(OP_PROCESS, 5, 198);
        send_pixel(OP_CLEAR, 5, 17);
        send_pixel(OP_PROCESS, 5, 255);
        // off-frame beats and the unused opcode leave the store alone
        send_pixel(OP_PROCESS, FRAME_PIXELS, 50);
        send_pixel(OP_CAPTURE, 2 ** IDX_W - 1, 77);
        send_pixel(OP_UNUSED, 7, 99);
        send_pixel(OP_PROCESS, 7, 0);
    endtask

    task automatic test_divisor_cases();
        set_config(0, 0);
        send_pixel(OP_CAPTURE, 20, 10);
        send_pixel(OP_PROCESS, 20, 250);
        set_config(0, 10);
        send_pixel(OP_PROCESS, 20, 250);
        send_pixel(OP_PROCESS, 20, 39);
        set_config(0, 15);
        send_pixel(OP_PROCESS, 20, 255);
        set_config(1, 11);
        send_pixel(OP_CAPTURE, 9, 0);
        send_pixel(OP_PROCESS, 9, 255);
    endtask

    task automatic test_random_settings();
        int autos [8] = '{0, 1, 0, 1, 1, 0, 1, 0};
        int divs [8];
        divs = '{1, 1, 10, 10, 0, 15, $urandom_range(2, 9), $urandom_range(11, 14)};
        for (int p = 0; p < 8; p++)
        begin
            hot_pool[0] = 0;
            hot_pool[1] = 1;
            hot_pool[2] = FRAME_PIXELS - 1;
            hot_pool[3] = 65536;
            for (int i = 4; i < 16; i++)
                hot_pool[i] = $urandom_range(0, FRAME_PIXELS - 1);
            set_config(autos[p], divs[p]);
            random_burst(130);
        end
    endtask

    // Receiver holds off while beats keep coming until the input stalls
    task automatic test_backpressure();
        set_config(1, 2);
        calm = 1'b1;
        hold_requests++;
        for (int i = 0; i < 40; i++)
            send_pixel(OP_PROCESS, $urandom_range(0, FRAME_PIXELS - 1), $urandom_range(0, 255));
        calm = 1'b0;
    endtask

    task automatic test_calm_stretch();
        set_config(1, 3);
        calm = 1'b1;
        random_burst(100);
        calm = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            res_stall <= 1'b1;
        end
        else if (holds_done < hold_requests)
        begin
            holds_done++;
            hold_left = HOLD_CYCLES - 1;
            res_stall <= 1'b1;
        end
        else
            res_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin : check_results
        res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            results_seen++;
            if (pending_fg_q.size() == 0)
                report_mismatch($sformatf("unexpected result idx %0d fg %0d",
                                          out_index, foreground));
            else
            begin
                want = pending_fg_q.pop_front();
                if (foreground !== want.fg)
                    report_mismatch($sformatf("foreground idx %0d got %0d want %0d",
                                              want.idx, foreground, want.fg));
                if (out_index !== want.idx)
                    report_mismatch($sformatf("out_index got %0d want %0d",
                                              out_index, want.idx));
            end
        end
    end

    // Covers the clearing pass after reset, which accepts no pixel beats
    initial
    begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((pix_valid && pix_stall === 1'b0) || (res_valid === 1'b1 && !res_stall)
                || (cfg_valid && cfg_ready === 1'b1))
                quiet_cycles = 0;
            else if (rst_n)
                quiet_cycles++;
        end
        $display("[%0t] timeout: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_plain_ops();
        test_divisor_cases();
        test_random_settings();
        test_backpressure();
        test_calm_stretch();
        wait_quiet();
        $display("Covered %0d pixel beats (%0d acting on the store), %0d results checked,",
                 beats_sent, live_items, results_seen);
        $display("%0d register writes incl. divisor 0, 1, 10, 15, auto blend on/off, %0d holds",
                 reg_writes, holds_done);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
